// ===== rtl/ihrp_pkg.sv =====
package ihrp_pkg;

    localparam int MAX_RECORD_BYTES = 255;

    localparam int CH_W    = 8;
    localparam int NIB_W   = 4;
    localparam int BYTE_W  = 8;
    localparam int DIGIT_W = 10;
    localparam int INDEX_W = 9;
    localparam int ADDR_W  = 16;
    localparam int BASE_W  = 32;
    localparam int LINE_W  = 20;
    localparam int KIND_W  = 2;
    localparam int RKIND_W = 3;
    localparam int ERR_W   = 3;
    localparam int RECENT_DEPTH = 4;

    localparam logic [DIGIT_W-1:0] DIGIT_MAX = '1;
    localparam logic [INDEX_W-1:0] INDEX_MAX = '1;
    localparam logic [LINE_W-1:0]  LINE_MAX  = '1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef logic [2:0] cls_t;

    localparam cls_t CLS_CR    = 3'd0;
    localparam cls_t CLS_LF    = 3'd1;
    localparam cls_t CLS_COLON = 3'd2;
    localparam cls_t CLS_HEX   = 3'd3;
    localparam cls_t CLS_OTHER = 3'd4;

    localparam logic [CH_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CH_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CH_W-1:0] CHAR_COLON = 8'h3A;

    localparam logic [KIND_W-1:0] KIND_DATA   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

    localparam logic [ERR_W-1:0] ERR_NONE   = 3'd0;
    localparam logic [ERR_W-1:0] ERR_SYNTAX = 3'd1;
    localparam logic [ERR_W-1:0] ERR_ODD    = 3'd2;
    localparam logic [ERR_W-1:0] ERR_TYPE   = 3'd3;
    localparam logic [ERR_W-1:0] ERR_LENGTH = 3'd4;
    localparam logic [ERR_W-1:0] ERR_CSUM   = 3'd5;
    localparam logic [ERR_W-1:0] ERR_OFFSET = 3'd6;

    localparam logic [BYTE_W-1:0] REC_DATA      = 8'd0;
    localparam logic [BYTE_W-1:0] REC_EXT_SEG   = 8'd2;
    localparam logic [BYTE_W-1:0] REC_START_SEG = 8'd3;
    localparam logic [BYTE_W-1:0] REC_EXT_LIN   = 8'd4;
    localparam logic [BYTE_W-1:0] REC_START_LIN = 8'd5;
    localparam logic [BYTE_W-1:0] REC_TYPE_MAX  = 8'd5;

    typedef struct packed {
        cls_t             cls;
        logic [NIB_W-1:0] nib;
    } entry_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [BYTE_W-1:0]  data_value;
        logic [ADDR_W-1:0]  address;
        logic [RKIND_W-1:0] record_kind;
        logic [BASE_W-1:0]  base_address;
        logic [ERR_W-1:0]   error_code;
        logic [LINE_W-1:0]  line_number;
    } result_t;

endpackage

// ===== rtl/ihrp_front.sv =====
module ihrp_front (
    input  logic [ihrp_pkg::CH_W-1:0] ch,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      q_full,
    output logic                      q_push,
    output ihrp_pkg::entry_t          q_entry
);

    always_comb
    begin
        q_entry.nib = '0;
        if (ch == ihrp_pkg::CHAR_CR)
        begin
            q_entry.cls = ihrp_pkg::CLS_CR;
        end
        else if (ch == ihrp_pkg::CHAR_LF)
        begin
            q_entry.cls = ihrp_pkg::CLS_LF;
        end
        else if (ch == ihrp_pkg::CHAR_COLON)
        begin
            q_entry.cls = ihrp_pkg::CLS_COLON;
        end
        else if (ch inside {[8'h30:8'h39]})
        begin
            q_entry.cls = ihrp_pkg::CLS_HEX;
            q_entry.nib = ch[3:0];
        end
        else if (ch inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            q_entry.cls = ihrp_pkg::CLS_HEX;
            q_entry.nib = ch[3:0] + 4'd9;
        end
        else
        begin
            q_entry.cls = ihrp_pkg::CLS_OTHER;
        end
    end

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

endmodule

// ===== rtl/ihrp_queue.sv =====
module ihrp_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ihrp_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output ihrp_pkg::entry_t head
);

    ihrp_pkg::entry_t                  slot_reg [ihrp_pkg::QUEUE_DEPTH];
    logic [ihrp_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [ihrp_pkg::QPTR_W-1:0]       wr_ptr_next;
    logic [ihrp_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [ihrp_pkg::QPTR_W-1:0]       rd_ptr_next;
    logic [ihrp_pkg::QCNT_W-1:0]       count_reg;
    logic [ihrp_pkg::QCNT_W-1:0]       count_next;

    localparam logic [ihrp_pkg::QPTR_W-1:0] LAST_PTR =
        ihrp_pkg::QPTR_W'(ihrp_pkg::QUEUE_DEPTH - 1);
    localparam logic [ihrp_pkg::QCNT_W-1:0] DEPTH_CNT =
        ihrp_pkg::QCNT_W'(ihrp_pkg::QUEUE_DEPTH);

    assign full      = (count_reg == DEPTH_CNT);
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/ihrp_back.sv =====
module ihrp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             skip_bad_records,
    input  logic             q_valid,
    input  ihrp_pkg::entry_t q_entry,
    output logic             q_pop,
    input  logic             out_ready,
    output logic             out_valid,
    output ihrp_pkg::result_t res
);

    logic                                in_line_reg, in_line_next;
    logic [ihrp_pkg::ERR_W-1:0]          pend_reg, pend_next;
    logic [ihrp_pkg::DIGIT_W-1:0]        digit_count_reg, digit_count_next;
    logic [ihrp_pkg::NIB_W-1:0]          high_nibble_reg, high_nibble_next;
    logic [ihrp_pkg::BYTE_W-1:0]         held_byte_reg, held_byte_next;
    logic                                held_valid_reg, held_valid_next;
    logic [ihrp_pkg::BYTE_W-1:0]         length_reg, length_next;
    logic [ihrp_pkg::ADDR_W-1:0]         offset_reg, offset_next;
    logic [ihrp_pkg::BYTE_W-1:0]         type_reg, type_next;
    logic [ihrp_pkg::BYTE_W-1:0]         sum_reg, sum_next;
    logic [ihrp_pkg::INDEX_W-1:0]        data_index_reg, data_index_next;
    logic [ihrp_pkg::BYTE_W-1:0]         recent_reg [ihrp_pkg::RECENT_DEPTH];
    logic [ihrp_pkg::BYTE_W-1:0]         recent_next [ihrp_pkg::RECENT_DEPTH];
    logic [ihrp_pkg::LINE_W-1:0]         line_count_reg, line_count_next;
    logic                                halted_reg, halted_next;
    logic                                out_valid_reg, out_valid_next;
    ihrp_pkg::result_t                   res_reg, res_next;

    logic [ihrp_pkg::BYTE_W-1:0]         byte_val;
    logic [ihrp_pkg::INDEX_W-1:0]        byte_idx;
    logic [ihrp_pkg::INDEX_W-1:0]        pos;
    logic [ihrp_pkg::INDEX_W-1:0]        length_ext;
    logic                                length_ok;
    logic [ihrp_pkg::BYTE_W-1:0]         d [ihrp_pkg::RECENT_DEPTH];
    logic [ihrp_pkg::ERR_W-1:0]          fin_err;
    logic [ihrp_pkg::BASE_W-1:0]         fin_base;
    logic [ihrp_pkg::RKIND_W-1:0]        fin_rkind;

    assign q_pop      = q_valid && (!out_valid_reg || out_ready);
    assign byte_val   = {high_nibble_reg, q_entry.nib};
    assign byte_idx   = digit_count_reg[ihrp_pkg::DIGIT_W-1:1];
    assign pos        = data_index_reg - 1'b1;
    assign length_ext = {1'b0, length_reg};
    assign length_ok  = (length_ext <= ihrp_pkg::INDEX_W'(ihrp_pkg::MAX_RECORD_BYTES));

    always_comb
    begin
        for (int i = 0; i < ihrp_pkg::RECENT_DEPTH; i++)
        begin
            d[i] = (length_reg > ihrp_pkg::BYTE_W'(i)) ? recent_reg[i] : '0;
        end
    end

    always_comb
    begin
        fin_rkind = '0;
        if (digit_count_reg >= ihrp_pkg::DIGIT_W'(8) && type_reg <= ihrp_pkg::REC_TYPE_MAX)
        begin
            fin_rkind = type_reg[ihrp_pkg::RKIND_W-1:0];
        end

        if (digit_count_reg[0])
        begin
            fin_err = ihrp_pkg::ERR_ODD;
        end
        else if (pend_reg != ihrp_pkg::ERR_NONE)
        begin
            fin_err = pend_reg;
        end
        else if (digit_count_reg < ihrp_pkg::DIGIT_W'(10))
        begin
            fin_err = ihrp_pkg::ERR_SYNTAX;
        end
        else if (!length_ok || data_index_reg != (length_ext + 1'b1))
        begin
            fin_err = ihrp_pkg::ERR_LENGTH;
        end
        else if (sum_reg != '0)
        begin
            fin_err = ihrp_pkg::ERR_CSUM;
        end
        else if (type_reg != ihrp_pkg::REC_DATA && offset_reg != '0)
        begin
            fin_err = ihrp_pkg::ERR_OFFSET;
        end
        else
        begin
            fin_err = ihrp_pkg::ERR_NONE;
        end

        fin_base = '0;
        if (fin_err == ihrp_pkg::ERR_NONE)
        begin
            case (type_reg)
                ihrp_pkg::REC_EXT_SEG:
                begin
                    fin_base = {12'd0, d[0], d[1], 4'd0};
                end
                ihrp_pkg::REC_START_SEG, ihrp_pkg::REC_START_LIN:
                begin
                    fin_base = {d[0], d[1], d[2], d[3]};
                end
                ihrp_pkg::REC_EXT_LIN:
                begin
                    fin_base = {d[0], d[1], 16'd0};
                end
                default:
                begin
                    fin_base = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        in_line_next     = in_line_reg;
        pend_next        = pend_reg;
        digit_count_next = digit_count_reg;
        high_nibble_next = high_nibble_reg;
        held_byte_next   = held_byte_reg;
        held_valid_next  = held_valid_reg;
        length_next      = length_reg;
        offset_next      = offset_reg;
        type_next        = type_reg;
        sum_next         = sum_reg;
        data_index_next  = data_index_reg;
        recent_next      = recent_reg;
        line_count_next  = line_count_reg;
        halted_next      = halted_reg;
        res_next         = res_reg;
        out_valid_next   = out_valid_reg && !out_ready;

        if (q_pop && !halted_reg)
        begin
            case (q_entry.cls)
                ihrp_pkg::CLS_CR:
                begin
                end
                ihrp_pkg::CLS_LF:
                begin
                    if (in_line_reg)
                    begin
                        out_valid_next        = 1'b1;
                        res_next.kind         = (fin_err == ihrp_pkg::ERR_NONE) ?
                                                ihrp_pkg::KIND_ACCEPT : ihrp_pkg::KIND_REJECT;
                        res_next.data_value   = '0;
                        res_next.address      = offset_reg;
                        res_next.record_kind  = fin_rkind;
                        res_next.base_address = fin_base;
                        res_next.error_code   = fin_err;
                        res_next.line_number  = line_count_reg;
                        if (fin_err != ihrp_pkg::ERR_NONE && !skip_bad_records)
                        begin
                            halted_next = 1'b1;
                        end
                    end
                    in_line_next     = 1'b0;
                    pend_next        = '0;
                    digit_count_next = '0;
                    high_nibble_next = '0;
                    held_byte_next   = '0;
                    held_valid_next  = 1'b0;
                    length_next      = '0;
                    offset_next      = '0;
                    type_next        = '0;
                    sum_next         = '0;
                    data_index_next  = '0;
                    for (int i = 0; i < ihrp_pkg::RECENT_DEPTH; i++)
                    begin
                        recent_next[i] = '0;
                    end
                    if (line_count_reg != ihrp_pkg::LINE_MAX)
                    begin
                        line_count_next = line_count_reg + 1'b1;
                    end
                end
                default:
                begin
                    if (!in_line_reg)
                    begin
                        in_line_next = 1'b1;
                        if (q_entry.cls != ihrp_pkg::CLS_COLON && pend_reg == ihrp_pkg::ERR_NONE)
                        begin
                            pend_next = ihrp_pkg::ERR_SYNTAX;
                        end
                    end
                    else if (q_entry.cls != ihrp_pkg::CLS_HEX)
                    begin
                        if (pend_reg == ihrp_pkg::ERR_NONE)
                        begin
                            pend_next = ihrp_pkg::ERR_SYNTAX;
                        end
                    end
                    else if (digit_count_reg != ihrp_pkg::DIGIT_MAX)
                    begin
                        digit_count_next = digit_count_reg + 1'b1;
                        if (!digit_count_reg[0])
                        begin
                            high_nibble_next = q_entry.nib;
                        end
                        else
                        begin
                            sum_next = sum_reg + byte_val;
                            if (byte_idx == ihrp_pkg::INDEX_W'(0))
                            begin
                                length_next = byte_val;
                            end
                            else if (byte_idx == ihrp_pkg::INDEX_W'(1))
                            begin
                                offset_next = {byte_val, 8'd0};
                            end
                            else if (byte_idx == ihrp_pkg::INDEX_W'(2))
                            begin
                                offset_next = offset_reg | {8'd0, byte_val};
                            end
                            else if (byte_idx == ihrp_pkg::INDEX_W'(3))
                            begin
                                type_next = byte_val;
                                if (byte_val > ihrp_pkg::REC_TYPE_MAX &&
                                    pend_reg == ihrp_pkg::ERR_NONE)
                                begin
                                    pend_next = ihrp_pkg::ERR_TYPE;
                                end
                            end
                            else
                            begin
                                if (held_valid_reg && pend_reg == ihrp_pkg::ERR_NONE &&
                                    type_reg == ihrp_pkg::REC_DATA && length_ok &&
                                    pos < length_ext)
                                begin
                                    out_valid_next        = 1'b1;
                                    res_next.kind         = ihrp_pkg::KIND_DATA;
                                    res_next.data_value   = held_byte_reg;
                                    res_next.address      = offset_reg + {7'd0, pos};
                                    res_next.record_kind  = '0;
                                    res_next.base_address = '0;
                                    res_next.error_code   = ihrp_pkg::ERR_NONE;
                                    res_next.line_number  = line_count_reg;
                                end
                                held_byte_next  = byte_val;
                                held_valid_next = 1'b1;
                                if (data_index_reg < ihrp_pkg::INDEX_W'(ihrp_pkg::RECENT_DEPTH))
                                begin
                                    recent_next[data_index_reg[1:0]] = byte_val;
                                end
                                if (data_index_reg != ihrp_pkg::INDEX_MAX)
                                begin
                                    data_index_next = data_index_reg + 1'b1;
                                end
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_line_reg     <= 1'b0;
            pend_reg        <= '0;
            digit_count_reg <= '0;
            high_nibble_reg <= '0;
            held_byte_reg   <= '0;
            held_valid_reg  <= 1'b0;
            length_reg      <= '0;
            offset_reg      <= '0;
            type_reg        <= '0;
            sum_reg         <= '0;
            data_index_reg  <= '0;
            for (int i = 0; i < ihrp_pkg::RECENT_DEPTH; i++)
            begin
                recent_reg[i] <= '0;
            end
            line_count_reg  <= '0;
            halted_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            in_line_reg     <= in_line_next;
            pend_reg        <= pend_next;
            digit_count_reg <= digit_count_next;
            high_nibble_reg <= high_nibble_next;
            held_byte_reg   <= held_byte_next;
            held_valid_reg  <= held_valid_next;
            length_reg      <= length_next;
            offset_reg      <= offset_next;
            type_reg        <= type_next;
            sum_reg         <= sum_next;
            data_index_reg  <= data_index_next;
            recent_reg      <= recent_next;
            line_count_reg  <= line_count_next;
            halted_reg      <= halted_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("Halt cleared without reset.");

    a_halt_on_reject: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(halted_reg) |-> out_valid_reg && res_reg.kind == ihrp_pkg::KIND_REJECT)
        else $error("Halt entered without a rejected record status.");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (res_reg.kind == ihrp_pkg::KIND_REJECT) ==
                          (res_reg.error_code != ihrp_pkg::ERR_NONE))
        else $error("Status kind disagrees with error code.");

    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.kind == ihrp_pkg::KIND_DATA |->
            res_reg.record_kind == '0 && res_reg.base_address == '0)
        else $error("Data byte transaction carries status fields.");

    a_idle_line: assert property (@(posedge clk) disable iff (!rst_n)
        !in_line_reg |-> digit_count_reg == '0 && !held_valid_reg)
        else $error("Line state left over outside a line.");

endmodule

// ===== rtl/intel_hex_record_parser_top.sv =====
// Intel HEX record parser. One ASCII character is taken per transaction on
// the input channel, and the block sustains one character per clock cycle
// while out_ready does not hold back the output: a classifier decodes each
// character into a two-entry queue, and the line parser behind it retires
// one queued character per cycle, unless the output stalls, into a single
// output register, so throughput is set by that one-per-cycle parser step.
// A character is stored in the queue and its result in the output register.
// Each type-0 data byte comes out as its own transaction with its address,
// one byte behind, and each non-empty line ends with one status transaction
// carrying the record type, base address, error code and line number. With
// skip_bad_records low, a rejected record halts the block until reset.
module intel_hex_record_parser_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ihrp_pkg::CH_W-1:0]         ch,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ihrp_pkg::KIND_W-1:0]       kind,
    output logic [ihrp_pkg::BYTE_W-1:0]       data_value,
    output logic [ihrp_pkg::ADDR_W-1:0]       address,
    output logic [ihrp_pkg::RKIND_W-1:0]      record_kind,
    output logic [ihrp_pkg::BASE_W-1:0]       base_address,
    output logic [ihrp_pkg::ERR_W-1:0]        error_code,
    output logic [ihrp_pkg::LINE_W-1:0]       line_number
);

    logic              skip_reg;
    logic              q_full;
    logic              q_push;
    ihrp_pkg::entry_t  push_entry;
    logic              q_pop;
    logic              q_not_empty;
    ihrp_pkg::entry_t  q_head;
    ihrp_pkg::result_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            skip_reg <= cfg_wdata;
        end
    end

    ihrp_front u_front (
        .ch       (ch),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    ihrp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    ihrp_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .skip_bad_records (skip_reg),
        .q_valid          (q_not_empty),
        .q_entry          (q_head),
        .q_pop            (q_pop),
        .out_ready        (out_ready),
        .out_valid        (out_valid),
        .res              (res)
    );

    assign kind         = res.kind;
    assign data_value   = res.data_value;
    assign address      = res.address;
    assign record_kind  = res.record_kind;
    assign base_address = res.base_address;
    assign error_code   = res.error_code;
    assign line_number  = res.line_number;

endmodule
